// ----- rtl/core/rhsv_pkg.sv -----
// ============================================================================
// rhsv_pkg - shared types and constants for the RGB to HSV pipeline
// Holds the per-stage payload structs, hue offsets and the restoring
// divide step used by every divider stage.
// ============================================================================
package rhsv_pkg;

    localparam int unsigned CHAN_W     = 8;
    localparam int unsigned SAT_NUM_W  = 16;   // 255 * chroma
    localparam int unsigned HUE_NUM_W  = 14;   // 43 * |diff|, at most 10965
    localparam int unsigned SAT_STEPS  = 8;    // quotient below 256
    localparam int unsigned HUE_STEPS  = 6;    // quotient at most 43
    localparam int unsigned DIV_STAGES = 8;

    localparam logic [CHAN_W-1:0] OFFSET_RED   = 8'd0;
    localparam logic [CHAN_W-1:0] OFFSET_GREEN = 8'd85;
    localparam logic [CHAN_W-1:0] OFFSET_BLUE  = 8'd171;
    localparam logic [7:0]        HUE_STEP     = 8'd43;

    // Stage 1: max/min classification
    typedef struct packed {
        logic              valid;
        logic              zero;      // chroma is zero: hue and saturation forced to zero
        logic              neg;       // hue term is negative
        logic [CHAN_W-1:0] offset;
        logic [CHAN_W-1:0] value;
        logic [CHAN_W-1:0] chroma;
        logic [CHAN_W-1:0] dmag;
    } t_class;

    // Stage 2: numerators ready for division
    typedef struct packed {
        logic                 valid;
        logic                 zero;
        logic                 neg;
        logic [CHAN_W-1:0]    offset;
        logic [CHAN_W-1:0]    value;
        logic [CHAN_W-1:0]    chroma;
        logic [SAT_NUM_W-1:0] sat_num;
        logic [HUE_NUM_W-1:0] hue_num;
    } t_mul;

    // Divider stages: partial remainders, unconsumed numerator bits, quotients
    typedef struct packed {
        logic                 valid;
        logic                 zero;
        logic                 neg;
        logic [CHAN_W-1:0]    offset;
        logic [CHAN_W-1:0]    value;
        logic [CHAN_W-1:0]    chroma;
        logic [CHAN_W-1:0]    sat_rem;
        logic [SAT_STEPS-1:0] sat_low;
        logic [SAT_STEPS-1:0] sat_q;
        logic [CHAN_W-1:0]    hue_rem;
        logic [HUE_STEPS-1:0] hue_low;
        logic [HUE_STEPS-1:0] hue_q;
    } t_div;

    // One restoring step: returns {quotient bit, new remainder}.
    // Requires rem < den, which keeps the new remainder below den.
    function automatic logic [CHAN_W:0] div_step(
        input logic [CHAN_W-1:0] rem,
        input logic              nb,
        input logic [CHAN_W-1:0] den
    );
        logic [CHAN_W:0] trial;
        logic [CHAN_W:0] diff;
        trial = {rem, nb};
        diff  = trial - {1'b0, den};
        if (trial >= {1'b0, den}) begin
            div_step = {1'b1, diff[CHAN_W-1:0]};
        end else begin
            div_step = {1'b0, trial[CHAN_W-1:0]};
        end
    endfunction

endpackage

// ----- rtl/core/rgb_to_hsv_8bit_core.sv -----
// ============================================================================
// rgb_to_hsv_8bit_core - pipelined 8-bit RGB to HSV converter
// Converts one pixel per clock to 8-bit hue, saturation and value.
// ============================================================================
// Usage:
//   Input channel: drive i_red/i_green/i_blue and raise start. A transfer
//   takes place at each rising edge with start high and busy low. busy is
//   low whenever reset is released, so a new pixel may be given every cycle.
//   Output channel: o_valid strobes for exactly one cycle with o_hue,
//   o_saturation and o_value; the receiver must take the transfer then, as
//   the block cannot hold results back and never needs to.
//   Pipeline: each pixel passes through the classify and multiply stages,
//   8 divider stages and the output register, in that order.
//   Throughput: one pixel per cycle, set by the divider, which is unrolled
//   into one restoring step per stage: saturation in all, hue in the first six.
//   Reset (synchronous, active low) drops every pixel in flight; busy is
//   high while reset is asserted so no pixel is taken then.
//   Results leave in the order the pixels arrived.
// ============================================================================
module rgb_to_hsv_8bit_core
    import rhsv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [CHAN_W-1:0] i_red,
    input  logic [CHAN_W-1:0] i_green,
    input  logic [CHAN_W-1:0] i_blue,
    output logic              o_valid,
    output logic [CHAN_W-1:0] o_hue,
    output logic [CHAN_W-1:0] o_saturation,
    output logic [CHAN_W-1:0] o_value
);

    logic accept;

    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    // ------------------------------------------------------------------
    // Stage 1: find max/min, pick the hue sector, form |diff| and sign.
    // Red wins ties for the maximum, then green.
    // ------------------------------------------------------------------
    t_class            n_cls, r_cls;
    logic [CHAN_W-1:0] w_hi, w_lo, w_a, w_b;

    always_comb begin
        w_hi         = i_blue;
        w_a          = i_red;
        w_b          = i_green;
        n_cls.offset = OFFSET_BLUE;
        if (i_red >= i_green && i_red >= i_blue) begin
            w_hi         = i_red;
            w_a          = i_green;
            w_b          = i_blue;
            n_cls.offset = OFFSET_RED;
        end else if (i_green >= i_blue) begin
            w_hi         = i_green;
            w_a          = i_blue;
            w_b          = i_red;
            n_cls.offset = OFFSET_GREEN;
        end
        w_lo = (i_red < i_green) ? i_red : i_green;
        if (i_blue < w_lo) begin
            w_lo = i_blue;
        end
        n_cls.valid  = accept;
        n_cls.value  = w_hi;
        n_cls.chroma = w_hi - w_lo;
        n_cls.zero   = (w_hi == w_lo);
        n_cls.neg    = (w_a < w_b);
        n_cls.dmag   = (w_a >= w_b) ? (w_a - w_b) : (w_b - w_a);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cls.valid <= 1'b0;
        end else begin
            r_cls <= n_cls;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: numerators. 255*chroma is a shift and subtract; 43*|diff|
    // is a small constant multiply.
    // ------------------------------------------------------------------
    t_mul n_mul, r_mul;

    always_comb begin
        n_mul.valid   = r_cls.valid;
        n_mul.zero    = r_cls.zero;
        n_mul.neg     = r_cls.neg;
        n_mul.offset  = r_cls.offset;
        n_mul.value   = r_cls.value;
        n_mul.chroma  = r_cls.chroma;
        n_mul.sat_num = {r_cls.chroma, 8'd0} - {8'd0, r_cls.chroma};
        n_mul.hue_num = HUE_NUM_W'({6'd0, r_cls.dmag} * {6'd0, HUE_STEP});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul.valid <= 1'b0;
        end else begin
            r_mul <= n_mul;
        end
    end

    // ------------------------------------------------------------------
    // Divider stages. The top numerator bits start as the remainder: the
    // quotient bounds (below 256 and below 64) keep them under the divisor.
    // Saturation divides by value, the hue term by chroma.
    // ------------------------------------------------------------------
    t_div w_div_in;
    t_div w_src [DIV_STAGES];
    t_div n_div [DIV_STAGES];
    t_div r_div [DIV_STAGES];

    always_comb begin
        w_div_in.valid   = r_mul.valid;
        w_div_in.zero    = r_mul.zero;
        w_div_in.neg     = r_mul.neg;
        w_div_in.offset  = r_mul.offset;
        w_div_in.value   = r_mul.value;
        w_div_in.chroma  = r_mul.chroma;
        w_div_in.sat_rem = r_mul.sat_num[SAT_NUM_W-1:SAT_STEPS];
        w_div_in.sat_low = r_mul.sat_num[SAT_STEPS-1:0];
        w_div_in.sat_q   = '0;
        w_div_in.hue_rem = r_mul.hue_num[HUE_NUM_W-1:HUE_STEPS];
        w_div_in.hue_low = r_mul.hue_num[HUE_STEPS-1:0];
        w_div_in.hue_q   = '0;
    end

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        logic [CHAN_W:0] w_sat_step;
        logic [CHAN_W:0] w_hue_step;

        if (k == 0) begin : g_first
            assign w_src[k] = w_div_in;
        end else begin : g_next
            assign w_src[k] = r_div[k-1];
        end

        assign w_sat_step = div_step(w_src[k].sat_rem, w_src[k].sat_low[SAT_STEPS-1],
                                     w_src[k].value);
        assign w_hue_step = div_step(w_src[k].hue_rem, w_src[k].hue_low[HUE_STEPS-1],
                                     w_src[k].chroma);

        always_comb begin
            n_div[k]         = w_src[k];
            n_div[k].sat_rem = w_sat_step[CHAN_W-1:0];
            n_div[k].sat_low = {w_src[k].sat_low[SAT_STEPS-2:0], 1'b0};
            n_div[k].sat_q   = {w_src[k].sat_q[SAT_STEPS-2:0], w_sat_step[CHAN_W]};
            // hue quotient needs only the first six steps; hold it after that
            if (k < HUE_STEPS) begin
                n_div[k].hue_rem = w_hue_step[CHAN_W-1:0];
                n_div[k].hue_low = {w_src[k].hue_low[HUE_STEPS-2:0], 1'b0};
                n_div[k].hue_q   = {w_src[k].hue_q[HUE_STEPS-2:0], w_hue_step[CHAN_W]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_div[k].valid <= 1'b0;
            end else begin
                r_div[k] <= n_div[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: apply the sign to the hue term, add the sector offset
    // (wraps mod 256), force zero hue and saturation for grey and black.
    // ------------------------------------------------------------------
    t_div              w_last;
    logic [CHAN_W-1:0] w_term;
    logic [CHAN_W-1:0] n_hue, n_sat;
    logic              r_valid;
    logic [CHAN_W-1:0] r_hue, r_sat, r_val;

    assign w_last = r_div[DIV_STAGES-1];
    assign w_term = {{(CHAN_W-HUE_STEPS){1'b0}}, w_last.hue_q};

    always_comb begin
        if (w_last.zero) begin
            n_hue = '0;
            n_sat = '0;
        end else begin
            n_hue = w_last.neg ? (w_last.offset - w_term) : (w_last.offset + w_term);
            n_sat = w_last.sat_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_last.valid;
            r_hue   <= n_hue;
            r_sat   <= n_sat;
            r_val   <= w_last.value;
        end
    end

    assign o_valid      = r_valid;
    assign o_hue        = r_hue;
    assign o_saturation = r_sat;
    assign o_value      = r_val;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_grey_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_saturation == '0) |-> (o_hue == '0))
        else $error("hue not zero for a grey pixel");

    a_black_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_value == '0) |-> (o_saturation == '0))
        else $error("saturation not zero for a black pixel");

    a_cls_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cls.valid |=> r_mul.valid)
        else $error("pixel dropped between classify and multiply stages");

    a_div_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div[DIV_STAGES-1].valid |=> o_valid)
        else $error("pixel dropped at the output register");

endmodule

// ----- bench/tb.sv -----
// ============================================================================
// tb - self-checking bench for rgb_to_hsv_8bit_core
// Sends directed and random RGB pixels through the command interface with
// random gaps and back-to-back runs, predicts hue, saturation and value for
// each transfer, and compares every output strobe with the oldest prediction.
// ============================================================================
module tb;
    import rhsv_pkg::*;

    localparam int FULL_SCALE   = 255;
    localparam int IDLE_LIMIT   = 1000;   // cycles with no transfer on either side
    localparam int DRAIN_CYCLES = 16;     // extra wait for a stray late strobe
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic [CHAN_W-1:0] hue;
        logic [CHAN_W-1:0] sat;
        logic [CHAN_W-1:0] val;
    } t_hsv;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start   = 1'b0;
    logic              busy;
    logic [CHAN_W-1:0] i_red   = '0;
    logic [CHAN_W-1:0] i_green = '0;
    logic [CHAN_W-1:0] i_blue  = '0;
    logic              o_valid;
    logic [CHAN_W-1:0] o_hue;
    logic [CHAN_W-1:0] o_saturation;
    logic [CHAN_W-1:0] o_value;

    // Predictions waiting for their output strobe, oldest first.
    t_hsv pending_hsv[$];
    int   fault_count = 0;
    int   idle_cycles = 0;
    int   run_left    = 0;    // pixels still to send with no gap

    rgb_to_hsv_8bit_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .o_valid      (o_valid),
        .o_hue        (o_hue),
        .o_saturation (o_saturation),
        .o_value      (o_value)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predict the converter output for one pixel. Value is the largest
    // channel; saturation is chroma scaled to 255 over value; hue is the
    // sector offset of the winning channel plus a signed term, wrapped to
    // 8 bits. Ties go to red, then green.
    function automatic t_hsv hsv_of_pixel(input logic [CHAN_W-1:0] r,
                                          input logic [CHAN_W-1:0] g,
                                          input logic [CHAN_W-1:0] b);
        int   hi;
        int   lo;
        int   chroma;
        int   sat;
        int   offset;
        int   diff;
        int   hue_sum;
        t_hsv res;
        hi = (r > g) ? int'(r) : int'(g);
        if (b > hi) hi = int'(b);
        lo = (r < g) ? int'(r) : int'(g);
        if (b < lo) lo = int'(b);
        res     = '0;
        res.val = hi[CHAN_W-1:0];
        if (hi != 0) begin
            chroma  = hi - lo;
            sat     = (FULL_SCALE * chroma) / hi;
            res.sat = sat[CHAN_W-1:0];
            if (sat != 0) begin
                if (hi == int'(r)) begin
                    offset = int'(OFFSET_RED);
                    diff   = int'(g) - int'(b);
                end else if (hi == int'(g)) begin
                    offset = int'(OFFSET_GREEN);
                    diff   = int'(b) - int'(r);
                end else begin
                    offset = int'(OFFSET_BLUE);
                    diff   = int'(r) - int'(g);
                end
                // signed division truncates toward zero, so a negative term
                // pulls the hue below the offset, wrapping past zero for red
                hue_sum = offset + (int'(HUE_STEP) * diff) / chroma;
                res.hue = hue_sum[CHAN_W-1:0];
            end
        end
        return res;
    endfunction

    // Send one pixel: wait out a random gap (or none while in a run), hold
    // start high with the channels until the block takes the transfer, then
    // queue the prediction. start is left high so the next pixel can follow
    // on the very next edge.
    task automatic drive_pixel(input logic [CHAN_W-1:0] r,
                               input logic [CHAN_W-1:0] g,
                               input logic [CHAN_W-1:0] b);
        int gap;
        if (run_left > 0) begin
            gap = 0;
            run_left--;
        end else begin
            gap = $urandom_range(0, 16);
            if ($urandom_range(0, 7) == 0) run_left = $urandom_range(8, 40);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_red   <= r;
        i_green <= g;
        i_blue  <= b;
        do @(posedge i_clk); while (busy);
        pending_hsv.push_back(hsv_of_pixel(r, g, b));
    endtask

    // Extremes, black and grey pixels, each winning channel, ties for the
    // maximum and negative hue terms that wrap below zero.
    task automatic test_directed_pixels();
        drive_pixel(8'd0,   8'd0,   8'd0);      // black
        drive_pixel(8'd255, 8'd255, 8'd255);    // white
        drive_pixel(8'd128, 8'd128, 8'd128);    // grey
        drive_pixel(8'd1,   8'd1,   8'd1);
        drive_pixel(8'd255, 8'd0,   8'd0);      // pure red
        drive_pixel(8'd0,   8'd255, 8'd0);      // pure green
        drive_pixel(8'd0,   8'd0,   8'd255);    // pure blue
        drive_pixel(8'd255, 8'd0,   8'd255);    // red ties blue, term wraps
        drive_pixel(8'd255, 8'd255, 8'd0);      // red ties green
        drive_pixel(8'd0,   8'd255, 8'd255);    // green ties blue
        drive_pixel(8'd200, 8'd10,  8'd100);    // red max, negative term
        drive_pixel(8'd90,  8'd200, 8'd10);     // green max, negative term
        drive_pixel(8'd10,  8'd90,  8'd200);    // blue max, negative term
        drive_pixel(8'd200, 8'd100, 8'd10);     // red max, positive term
        drive_pixel(8'd1,   8'd0,   8'd0);      // smallest nonzero value
        drive_pixel(8'd255, 8'd254, 8'd254);    // smallest saturation
        drive_pixel(8'd2,   8'd1,   8'd1);      // saturation rounds down
        drive_pixel(8'd170, 8'd85,  8'd255);
        drive_pixel(8'd0,   8'd1,   8'd255);
        drive_pixel(8'd255, 8'd1,   8'd0);
    endtask

    // Uniform random pixels; every channel bit takes both values.
    task automatic test_random_pixels(input int count);
        repeat (count) begin
            drive_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)));
        end
    endtask

    // Pixels near grey and with shared channel values, where the choice of
    // winning channel, the zero-saturation cut and term truncation matter.
    task automatic test_near_ties(input int count);
        int base;
        int ch[3];
        repeat (count) begin
            base = $urandom_range(0, 255);
            foreach (ch[k]) begin
                ch[k] = base + $urandom_range(0, 6) - 3;
                if ($urandom_range(0, 3) == 0) ch[k] = base;
                if (ch[k] < 0)   ch[k] = 0;
                if (ch[k] > 255) ch[k] = 255;
            end
            drive_pixel(ch[0][CHAN_W-1:0], ch[1][CHAN_W-1:0], ch[2][CHAN_W-1:0]);
        end
    endtask

    // Check each output strobe against the oldest prediction.
    always @(posedge i_clk) begin
        t_hsv want;
        if (i_rst_n && o_valid) begin
            if (pending_hsv.size() == 0) begin
                fault_count++;
                if (fault_count <= REPORT_MAX)
                    $display("unexpected result: hue=%0d sat=%0d val=%0d",
                             o_hue, o_saturation, o_value);
            end else begin
                want = pending_hsv.pop_front();
                if (o_hue !== want.hue || o_saturation !== want.sat
                        || o_value !== want.val) begin
                    fault_count++;
                    if (fault_count <= REPORT_MAX)
                        $display("result mismatch: expected h/s/v %0d/%0d/%0d, got %0d/%0d/%0d",
                                 want.hue, want.sat, want.val,
                                 o_hue, o_saturation, o_value);
                end
            end
        end
    end

    // Watchdog: end the run if neither side transfers for too long.
    always @(posedge i_clk) begin
        if ((start && !busy && i_rst_n) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_pixels();
        test_random_pixels(1500);
        test_near_ties(500);
        start <= 1'b0;
        // drain the pipeline, then allow for a stray late strobe
        while (pending_hsv.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fault_count == 0 && pending_hsv.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/rhsv_pkg.sv
rtl/core/rgb_to_hsv_8bit_core.sv
bench/tb.sv
